[hdl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[hdl/wfa_pkg.sv]
package wfa_pkg;

   localparam int SIZE_W   = 8;
   localparam int START_W  = 7;
   localparam int STATUS_W = 3;

   localparam logic [SIZE_W-1:0] POOL_RESET = 8'd100;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_NO_FIT    = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_ZERO      = 3'd3,
      STATUS_BAD_START = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT,
      ST_INSERT,
      ST_MARK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              used;
      logic [SIZE_W-1:0] size;
   } seg_type;

endpackage

[hdl/wfa_if.sv]
interface wfa_req_if import wfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               command;
   logic [SIZE_W-1:0]  amount;
   logic [START_W-1:0] free_start;

   modport source (output valid, output command, output amount, output free_start,
                   input ready);
   modport sink (input valid, input command, input amount, input free_start,
                 output ready);
endinterface

interface wfa_rsp_if import wfa_pkg::*; ();
   logic               valid;
   logic               ready;
   status_type         status;
   logic [START_W-1:0] block_start;
   logic [SIZE_W-1:0]  block_size;

   modport source (output valid, output status, output block_start, output block_size,
                   input ready);
   modport sink (input valid, input status, input block_start, input block_size,
                 output ready);
endinterface

interface wfa_csr_if import wfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hdl/worst_fit_allocator.sv]
// Worst-fit segment allocator over a pool of up to 255 units (clamped to MEMORY_UNITS),
// kept as an address-ordered table of up to MAX_SEGMENTS segments in a single-port-write
// memory. Each request word is handled alone: req_chan.ready is high only when idle.
// A free or an allocate scans the live table through one subtract/compare unit, one
// entry per cycle. An allocate that splits a segment then moves every later entry up
// by one, one entry per cycle through the memory's single write port, and writes the
// remainder and the chosen entry. A zero-size allocate skips the scan and goes straight
// to the response. One response word can wait in the output register while the next
// request runs. After reset or a pool_size write the block rewrites entry 0 before it
// takes requests; the csr port is always ready.
`include "assert_macros.svh"

module worst_fit_allocator import wfa_pkg::*; #(
   parameter int MEMORY_UNITS = 128,
   parameter int MAX_SEGMENTS = 64
) (
   input logic       clock,
   input logic       reset,
   wfa_req_if.sink   req_chan,
   wfa_rsp_if.source rsp_chan,
   wfa_csr_if.sink   csr_chan
);

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [SIZE_W-1:0] POOL_MAX = (MEMORY_UNITS > 255) ? 8'd255 :
                                            SIZE_W'(MEMORY_UNITS);
   localparam logic [CW-1:0] CNT_FULL = CW'(MAX_SEGMENTS);

   seg_type mem [MAX_SEGMENTS];
   seg_type rdata_ff;

   state_type          state_ff, state_in;
   logic [SIZE_W-1:0]  pool_ff, pool_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               cmd_ff, cmd_in;
   logic [SIZE_W-1:0]  amount_ff, amount_in;
   logic [START_W-1:0] start_ff, start_in;
   logic [CW-1:0]      rd_idx_ff, rd_idx_in;
   logic [IW-1:0]      ev_idx_ff, ev_idx_in;
   logic               pend_ff, pend_in;
   logic [SIZE_W-1:0]  offset_ff, offset_in;
   logic               found_ff, found_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   logic [SIZE_W-1:0]  best_val_ff, best_val_in;   // remainder on allocate, size on free
   logic [SIZE_W-1:0]  best_start_ff, best_start_in;
   logic [IW-1:0]      sh_ptr_ff, sh_ptr_in;
   logic [IW-1:0]      sh_wa_ff, sh_wa_in;
   status_type         res_status_ff, res_status_in;
   logic [START_W-1:0] res_start_ff, res_start_in;
   logic [SIZE_W-1:0]  res_size_ff, res_size_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [START_W-1:0] rsp_start_ff, rsp_start_in;
   logic [SIZE_W-1:0]  rsp_size_ff, rsp_size_in;

   logic              we;
   logic [IW-1:0]     waddr;
   seg_type           wdata;
   logic [IW-1:0]     raddr;
   logic [SIZE_W:0]   diff;
   logic              fits;
   logic              better;
   logic              match;
   logic              req_acc;
   logic              csr_acc;
   logic [SIZE_W-1:0] csr_clamped;

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign csr_chan.ready     = 1'b1;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.block_start = rsp_start_ff;
   assign rsp_chan.block_size  = rsp_size_ff;

   assign req_acc = req_chan.valid && (state_ff == ST_IDLE);
   assign csr_acc = csr_chan.valid;

   always_comb begin
      if (csr_chan.data == '0) begin
         csr_clamped = SIZE_W'(1);
      end else if (csr_chan.data > POOL_MAX) begin
         csr_clamped = POOL_MAX;
      end else begin
         csr_clamped = csr_chan.data;
      end
   end

   // shared compare unit for the table scan
   assign diff   = {1'b0, rdata_ff.size} - {1'b0, amount_ff};
   assign fits   = !rdata_ff.used && !diff[SIZE_W];
   assign better = !found_ff || (diff[SIZE_W-1:0] > best_val_ff);
   assign match  = (offset_ff == {1'b0, start_ff});

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         pool_ff      <= POOL_RESET;
         cnt_ff       <= CW'(1);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      amount_ff     <= amount_in;
      start_ff      <= start_in;
      rd_idx_ff     <= rd_idx_in;
      ev_idx_ff     <= ev_idx_in;
      offset_ff     <= offset_in;
      found_ff      <= found_in;
      best_idx_ff   <= best_idx_in;
      best_val_ff   <= best_val_in;
      best_start_ff <= best_start_in;
      sh_ptr_ff     <= sh_ptr_in;
      sh_wa_ff      <= sh_wa_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_size_ff   <= res_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_size_ff   <= rsp_size_in;
   end

   always_comb begin
      state_in      = state_ff;
      pool_in       = pool_ff;
      cnt_in        = cnt_ff;
      cmd_in        = cmd_ff;
      amount_in     = amount_ff;
      start_in      = start_ff;
      rd_idx_in     = rd_idx_ff;
      ev_idx_in     = ev_idx_ff;
      pend_in       = pend_ff;
      offset_in     = offset_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_val_in   = best_val_ff;
      best_start_in = best_start_ff;
      sh_ptr_in     = sh_ptr_ff;
      sh_wa_in      = sh_wa_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_size_in   = res_size_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_size_in   = rsp_size_ff;
      we            = 1'b0;
      waddr         = '0;
      wdata         = '0;
      raddr         = '0;

      case (state_ff)
         ST_INIT: begin
            we       = 1'b1;
            wdata    = '{used: 1'b0, size: pool_ff};
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_acc) begin
               cmd_in    = req_chan.command;
               amount_in = req_chan.amount;
               start_in  = req_chan.free_start;
               rd_idx_in = '0;
               pend_in   = 1'b0;
               offset_in = '0;
               found_in  = 1'b0;
               if (req_chan.command == CMD_ALLOC && req_chan.amount == '0) begin
                  res_status_in = STATUS_ZERO;
                  res_start_in  = '0;
                  res_size_in   = '0;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // read one entry ahead, evaluate the entry read last cycle
            if (rd_idx_ff < cnt_ff) begin
               raddr     = rd_idx_ff[IW-1:0];
               ev_idx_in = rd_idx_ff[IW-1:0];
               rd_idx_in = rd_idx_ff + CW'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_DECIDE;
               end
            end
            if (pend_ff) begin
               offset_in = offset_ff + rdata_ff.size;
               if (cmd_ff == CMD_ALLOC) begin
                  if (fits && better) begin
                     found_in      = 1'b1;
                     best_idx_in   = ev_idx_ff;
                     best_val_in   = diff[SIZE_W-1:0];
                     best_start_in = offset_ff;
                  end
               end else if (match && !found_ff) begin
                  found_in      = 1'b1;
                  best_idx_in   = ev_idx_ff;
                  best_val_in   = rdata_ff.size;
                  best_start_in = offset_ff;
               end
            end
         end
         ST_DECIDE: begin
            state_in      = ST_DONE;
            res_start_in  = '0;
            res_size_in   = '0;
            if (cmd_ff == CMD_FREE) begin
               if (found_ff) begin
                  we            = 1'b1;
                  waddr         = best_idx_ff;
                  wdata         = '{used: 1'b0, size: best_val_ff};
                  res_status_in = STATUS_OK;
                  res_start_in  = best_start_ff[START_W-1:0];
                  res_size_in   = best_val_ff;
               end else begin
                  res_status_in = STATUS_BAD_START;
               end
            end else if (!found_ff) begin
               res_status_in = STATUS_NO_FIT;
            end else if (best_val_ff == '0) begin
               we            = 1'b1;
               waddr         = best_idx_ff;
               wdata         = '{used: 1'b1, size: amount_ff};
               res_status_in = STATUS_OK;
               res_start_in  = best_start_ff[START_W-1:0];
               res_size_in   = amount_ff;
            end else if (cnt_ff == CNT_FULL) begin
               res_status_in = STATUS_FULL;
            end else begin
               sh_ptr_in = IW'(cnt_ff - CW'(1));
               pend_in   = 1'b0;
               state_in  = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // move entries above the split point up by one
            if (pend_ff) begin
               we    = 1'b1;
               waddr = sh_wa_ff;
               wdata = rdata_ff;
            end
            if (sh_ptr_ff != best_idx_ff) begin
               raddr     = sh_ptr_ff;
               sh_wa_in  = sh_ptr_ff + IW'(1);
               sh_ptr_in = sh_ptr_ff - IW'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_INSERT;
               end
            end
         end
         ST_INSERT: begin
            we       = 1'b1;
            waddr    = best_idx_ff + IW'(1);
            wdata    = '{used: 1'b0, size: best_val_ff};
            state_in = ST_MARK;
         end
         ST_MARK: begin
            we            = 1'b1;
            waddr         = best_idx_ff;
            wdata         = '{used: 1'b1, size: amount_ff};
            cnt_in        = cnt_ff + CW'(1);
            res_status_in = STATUS_OK;
            res_start_in  = best_start_ff[START_W-1:0];
            res_size_in   = amount_ff;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               rsp_size_in   = res_size_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      // pool write reinitializes the table
      if (csr_acc) begin
         pool_in  = csr_clamped;
         cnt_in   = CW'(1);
         state_in = ST_INIT;
      end
   end

   `ASSERT_NEXT(a_cnt_step, clock, reset, !csr_acc, (cnt_ff == $past(cnt_ff)) || (cnt_ff == $past(cnt_ff) + CW'(1)), "segment count moved by more than one")
   `ASSERT_IMPLY(a_shift_room, clock, reset, state_ff == ST_SHIFT || state_ff == ST_INSERT, cnt_ff < CNT_FULL, "table shift with a full table")
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_acc && !csr_acc, state_ff != ST_IDLE, "still idle after taking a request")

endmodule
